// ===== hdl/ctds_pkg.sv =====
// Shared types for the call trace dedup store: beats, controller states, command and status.
package ctds_pkg;

	localparam int INDEX_W = 10;
	localparam int ADDR_W  = 64;

	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] frame_address;
		logic              last_frame;
	} in_beat_t;

	typedef struct packed {
		logic [INDEX_W-1:0] trace_index;
		logic               store_cleared;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_COPY,
		ST_TERM
	} ctl_state_t;

	typedef struct packed {
		logic take;
		logic scan_init;
		logic scan_step;
		logic copy_step;
		logic term_write;
	} ctl_cmd_t;

	typedef struct packed {
		logic close;
		logic scan_match;
		logic scan_append;
		logic copy_done;
	} dp_status_t;

endpackage

// ===== hdl/ctds_ctrl.sv =====
// Controller state machine: sequences accept, store scan, trace copy and terminator write.
module ctds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ctds_pkg::dp_status_t status,
	output ctds_pkg::ctl_cmd_t   cmd,
	output logic                busy
);
	import ctds_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.take = start;
				if (status.close) begin
					state_nx = ST_START;
				end
			end
			ST_START: begin
				cmd.scan_init = 1'b1;
				state_nx      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				priority if (status.scan_match) begin
					state_nx = ST_IDLE;
				end else if (status.scan_append) begin
					state_nx = ST_COPY;
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (status.copy_done) begin
					state_nx = ST_TERM;
				end
			end
			ST_TERM: begin
				cmd.term_write = 1'b1;
				state_nx       = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/ctds_datapath.sv =====
// Datapath: trace buffer, address store with fill mark, scan compare, copy and result register.
module ctds_datapath #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_FRAMES  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctds_pkg::in_beat_t   beat_in,
	input  ctds_pkg::ctl_cmd_t   cmd,
	output ctds_pkg::dp_status_t status,
	output logic                 res_valid,
	output ctds_pkg::out_beat_t  res
);
	import ctds_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int TW = AW + 1;
	localparam int FW = $clog2(MAX_FRAMES + 1);
	localparam int BW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = ((TW > FW) ? TW : FW) + 1;
	localparam int XW = TW + INDEX_W;
	localparam logic [TW-1:0] DEPTH_C = TW'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(STORE_DEPTH - 1);
	localparam logic [FW-1:0] MAXF_C  = FW'(MAX_FRAMES);

	logic [ADDR_W-1:0] store_mem [STORE_DEPTH];
	logic [ADDR_W-1:0] buf_mem   [MAX_FRAMES];
	logic [ADDR_W-1:0] st_rd_q;
	logic [ADDR_W-1:0] buf_rd_q;

	logic [TW-1:0] top_q;
	logic [FW-1:0] held_q;
	logic          res_valid_q;
	logic [FW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [FW-1:0] j_q;
	logic          pz_q;
	logic [TW-1:0] at_q;
	logic [TW-1:0] m_q;
	logic [TW-1:0] k_q;
	logic          cleared_q;
	out_beat_t     res_q;

	logic          keep_frame;
	logic [FW-1:0] held_nx;
	logic          wz;
	logic          j_full;
	logic          at_last;
	logic          is_end;
	logic          hit;
	logic [FW-1:0] j_nx;
	logic          sc_match;
	logic          sc_append;
	logic [TW-1:0] at_raw;
	logic          fits;
	logic [TW-1:0] at_sel;
	logic [TW-1:0] m_sel;
	logic [TW-1:0] match_idx;
	logic [XW-1:0] idx_ext;
	logic [AW-1:0] st_raddr;
	logic [BW-1:0] buf_raddr;
	logic          st_we;
	logic [TW-1:0] st_waddr;
	logic [ADDR_W-1:0] st_wdata;

	always_comb begin
		keep_frame = (beat_in.frame_address != '0) && (held_q < MAXF_C);
		held_nx    = keep_frame ? held_q + FW'(1) : held_q;
	end

	always_comb begin
		wz        = !({1'b0, i_q} < top_q) || (st_rd_q == '0);
		j_full    = (j_q == n_q);
		at_last   = (i_q == LAST_C);
		is_end    = (i_q == '0) || at_last || pz_q;
		hit       = !wz && (j_q < n_q) && (buf_rd_q == st_rd_q);
		j_nx      = wz ? j_q : (hit ? j_q + FW'(1) : '0);
		sc_match  = wz && j_full;
		sc_append = wz ? (!j_full && is_end) : at_last;
		at_raw    = wz ? {1'b0, i_q} : DEPTH_C;
		fits      = (CW'(at_raw) + CW'(n_q)) < CW'(STORE_DEPTH);
		at_sel    = fits ? at_raw : '0;
		m_sel     = (CW'(n_q) > CW'(STORE_DEPTH - 1)) ? TW'(STORE_DEPTH - 1) : TW'(n_q);
		match_idx = {1'b0, i_q} - TW'(n_q);
		idx_ext   = XW'(cmd.term_write ? at_q : match_idx);
	end

	always_comb begin
		st_raddr = cmd.scan_init ? '0 : i_q + AW'(1);
		priority if (cmd.scan_init) begin
			buf_raddr = '0;
		end else if (cmd.scan_step) begin
			buf_raddr = BW'(j_nx);
		end else begin
			buf_raddr = BW'(k_q);
		end
		st_we    = (cmd.copy_step && (k_q != '0)) || cmd.term_write;
		st_waddr = cmd.term_write ? at_q + m_q : at_q + k_q - TW'(1);
		st_wdata = cmd.term_write ? '0 : buf_rd_q;
	end

	always_comb begin
		status.close       = cmd.take && !beat_in.action && beat_in.last_frame && (held_nx != '0);
		status.scan_match  = sc_match;
		status.scan_append = sc_append;
		status.copy_done   = (k_q == m_q);
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[AW'(st_waddr)] <= st_wdata;
		end
		st_rd_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !beat_in.action && keep_frame) begin
			buf_mem[BW'(held_q)] <= beat_in.frame_address;
		end
		buf_rd_q <= buf_mem[buf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			held_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (beat_in.action) begin
					top_q  <= '0;
					held_q <= '0;
				end else begin
					held_q <= beat_in.last_frame ? '0 : held_nx;
				end
			end
			if (cmd.term_write) begin
				top_q <= at_q + m_q + TW'(1);
			end
			res_valid_q <= (cmd.scan_step && sc_match) || cmd.term_write;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !beat_in.action && beat_in.last_frame) begin
			n_q <= held_nx;
		end
		if (cmd.scan_init) begin
			i_q  <= '0;
			j_q  <= '0;
			pz_q <= 1'b0;
		end else if (cmd.scan_step) begin
			i_q  <= i_q + AW'(1);
			j_q  <= j_nx;
			pz_q <= wz;
			if (sc_append) begin
				at_q      <= at_sel;
				m_q       <= m_sel;
				cleared_q <= !fits;
				k_q       <= '0;
			end
		end else if (cmd.copy_step) begin
			k_q <= k_q + TW'(1);
		end
		if (cmd.scan_step && sc_match) begin
			res_q.trace_index   <= idx_ext[INDEX_W-1:0];
			res_q.store_cleared <= 1'b0;
		end else if (cmd.term_write) begin
			res_q.trace_index   <= idx_ext[INDEX_W-1:0];
			res_q.store_cleared <= cleared_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/call_trace_dedup_store_top.sv =====
// Top level of the call trace dedup store: controller, datapath and checks.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  command   | start / busy          | command (action, frame_address, last_frame)
//  result    | result_valid (strobe) | result (trace_index, store_cleared)
//
// A frame or clear beat that does not close a trace leaves busy low.
// A closing beat steps START, SCAN, COPY, TERM (START, SCAN on a match): w store words
// scanned one per cycle through the single store read port (up to STORE_DEPTH), m frames
// copied one per cycle. The result strobe is high in the first cycle with busy low.
// Reset clears control only; a fill mark makes words at or above it read as zero, so no
// clearing pass runs. The receiver cannot stall results.
module call_trace_dedup_store_top #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_FRAMES  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ctds_pkg::in_beat_t  command,
	output logic                result_valid,
	output ctds_pkg::out_beat_t result
);
	import ctds_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	ctds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ctds_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_FRAMES  (MAX_FRAMES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_in   (command),
		.cmd       (cmd),
		.status    (status),
		.res_valid (result_valid),
		.res       (result)
	);

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result beat while busy");

	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held longer than one cycle");

	a_frame_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !command.last_frame) |=> (!busy && !result_valid))
		else $error("non-closing beat stalled or produced a result");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command.action) |=> (!busy && !result_valid))
		else $error("clear beat stalled or produced a result");

endmodule
